// ===== src/ipd_pkg.sv =====
// Package: shared types, codes and constants of the +IPD frame extractor.
package ipd_pkg;

  // Field widths of the input and result words.
  localparam int REQ_W  = 2;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 16;
  localparam int TMO_W  = 16;
  localparam int KIND_W = 2;

  // Header window holds the last five received bytes.
  localparam int HDR_BYTES = 5;
  localparam int WIN_W     = HDR_BYTES * BYTE_W;
  localparam logic [WIN_W-1:0] HDR_PATTERN = 40'h2B4950442C;  // "+IPD,"

  localparam logic [BYTE_W-1:0] CHR_COLON = 8'h3A;  // ':'
  localparam logic [BYTE_W-1:0] CHR_ZERO  = 8'h30;  // '0'
  localparam int                DEC_BASE  = 10;

  // Width of the length product before the clamp (len*10 + byte).
  localparam int PROD_W = LEN_W + 5;
  localparam logic [PROD_W-1:0] LEN_MAX = PROD_W'((1 << LEN_W) - 1);

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_BYTE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_START = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] RK_PAYLOAD = 2'd0;
  localparam logic [KIND_W-1:0] RK_EMPTY   = 2'd1;
  localparam logic [KIND_W-1:0] RK_TIMEOUT = 2'd2;

  // Parser phases.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HUNT = 2'd1,
    PH_LEN  = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  // Input word.
  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [BYTE_W-1:0] rx_byte;
    logic [TMO_W-1:0]  timeout_ms;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [KIND_W-1:0] result_kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [LEN_W-1:0]  byte_index;
    logic [LEN_W-1:0]  frame_length;
    logic              last;
  } out_word_t;

  // Handshake between the input stage and the parser.
  typedef struct packed {
    logic valid;
    logic fire;
  } stage_ctl_t;

endpackage

// ===== src/ipd_in_stage.sv =====
// Input register stage: holds one accepted word until the parser consumes it.
module ipd_in_stage
  import ipd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_data,
  input  logic       out_free,
  output stage_ctl_t ctl,
  output in_word_t   word
);

  logic     valid_r, valid_nxt;
  in_word_t word_r;
  logic     load;

  // The held word moves on whenever the result register can take its outcome.
  assign ctl.valid = valid_r;
  assign ctl.fire  = valid_r && out_free;
  assign in_stall  = valid_r && !out_free;
  assign load      = in_valid && !in_stall;
  assign word      = word_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (ctl.fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= in_data;
    end
  end

`ifndef SYNTHESIS
  // A stall is only raised while a word is held.
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> valid_r) else $error("stall without a held word");

  // A held word that is not consumed stays held.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !ctl.fire) |=> valid_r) else $error("held word lost");

  // A word that is consumed with nothing new behind it leaves the stage empty.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.fire && !in_valid) |=> !valid_r) else $error("word consumed twice");
`endif

endmodule

// ===== src/ipd_parser.sv =====
// Parser state and the single-pass update for one input word.
module ipd_parser
  import ipd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  in_word_t  word,
  output logic      res_valid,
  output out_word_t res
);

  phase_t             phase_r, phase_nxt;
  logic [WIN_W-1:0]   win_r, win_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [LEN_W-1:0]   cnt_r, cnt_nxt;
  logic [TMO_W-1:0]   time_r, time_nxt;

  logic [WIN_W-1:0]   win_shift;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  len_digit;
  logic [LEN_W:0]     cnt_inc;
  logic               data_fin;
  logic               tick_out;
  logic               active;

  // Shared datapath terms.
  assign win_shift = {win_r[WIN_W-BYTE_W-1:0], word.rx_byte};
  assign prod      = PROD_W'(len_r) * PROD_W'(DEC_BASE) + PROD_W'(word.rx_byte);
  assign cnt_inc   = {1'b0, cnt_r} + {{LEN_W{1'b0}}, 1'b1};
  assign data_fin  = cnt_inc >= {1'b0, len_r};
  assign tick_out  = time_r <= TMO_W'(1);
  assign active    = phase_r != PH_IDLE;

  // Length digit: subtract '0', clamp below at zero and above at the maximum.
  always_comb begin
    if (prod < PROD_W'(CHR_ZERO)) begin
      len_digit = '0;
    end else if ((prod - PROD_W'(CHR_ZERO)) > LEN_MAX) begin
      len_digit = LEN_MAX;
    end else begin
      len_digit = prod - PROD_W'(CHR_ZERO);
    end
  end

  // Next-state logic.
  always_comb begin
    phase_nxt = phase_r;
    win_nxt   = win_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    time_nxt  = time_r;
    priority if (word.req_type == REQ_START) begin
      win_nxt   = '0;
      len_nxt   = '0;
      cnt_nxt   = '0;
      time_nxt  = word.timeout_ms;
      phase_nxt = (word.timeout_ms == '0) ? PH_IDLE : PH_HUNT;
    end else if (active && word.req_type == REQ_TICK) begin
      if (tick_out) begin
        phase_nxt = PH_IDLE;
        time_nxt  = '0;
      end else begin
        time_nxt = time_r - TMO_W'(1);
      end
    end else if (active && word.req_type == REQ_BYTE) begin
      unique case (phase_r)
        PH_HUNT: begin
          win_nxt = win_shift;
          if (win_shift == HDR_PATTERN) begin
            phase_nxt = PH_LEN;
            len_nxt   = '0;
          end
        end
        PH_LEN: begin
          if (word.rx_byte == CHR_COLON) begin
            if (len_r == '0) begin
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = PH_DATA;
              cnt_nxt   = '0;
            end
          end else begin
            len_nxt = len_digit[LEN_W-1:0];
          end
        end
        PH_DATA: begin
          cnt_nxt = cnt_inc[LEN_W-1:0];
          if (data_fin) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end else begin
      // The unused request code and words while idle leave the state alone.
      phase_nxt = phase_r;
    end
  end

  // Result logic.
  always_comb begin
    res_valid        = 1'b0;
    res.result_kind  = RK_TIMEOUT;
    res.payload_byte = '0;
    res.byte_index   = '0;
    res.frame_length = '0;
    res.last         = 1'b1;
    priority if (word.req_type == REQ_START) begin
      res_valid = word.timeout_ms == '0;
    end else if (active && word.req_type == REQ_TICK) begin
      res_valid = tick_out;
    end else if (active && word.req_type == REQ_BYTE) begin
      if (phase_r == PH_LEN && word.rx_byte == CHR_COLON && len_r == '0) begin
        res_valid       = 1'b1;
        res.result_kind = RK_EMPTY;
      end else if (phase_r == PH_DATA) begin
        res_valid        = 1'b1;
        res.result_kind  = RK_PAYLOAD;
        res.payload_byte = word.rx_byte;
        res.byte_index   = cnt_r;
        res.frame_length = len_r;
        res.last         = data_fin;
      end
    end else begin
      res_valid = 1'b0;
    end
  end

  // Phase and timer are control state; the rest is cleared with them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      win_r   <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      time_r  <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      win_r   <= win_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      time_r  <= time_nxt;
    end
  end

`ifndef SYNTHESIS
  // Payload is only streamed for a non-empty frame.
  a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (len_r != '0)) else $error("data phase with zero length");

  // The byte counter never reaches the frame length while streaming.
  a_data_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (cnt_r < len_r)) else $error("payload counter overran");

  // Any result flagged as a timeout leaves the parser idle.
  a_tmo_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && res_valid && res.result_kind == RK_TIMEOUT) |=> (phase_r == PH_IDLE))
    else $error("timeout did not end reception");
`endif

endmodule

// ===== src/ipd_frame_extractor.sv =====
// Top level of the +IPD frame extractor: input stage, parser and result register.
//
// Usage: modem bytes, one-millisecond ticks and start requests arrive as words
// on the in_ channel (valid/stall); a word is taken at an edge where in_valid
// is high and in_stall low. A start word arms the parser with a millisecond
// budget; it then hunts for "+IPD,", reads the decimal length up to ':' and
// streams the payload. Each payload byte, an empty-frame completion or a
// timeout leaves as one word on the out_ channel; other input words give none.
// A result reaches out_ through two registers: the word sits in the input register,
// and the parser outcome is then stored in the result register. Throughput: one
// word per cycle while the receiver does not stall; the parser update between
// the two registers is combinational.
// While the receiver stalls, the result register holds its word and the input
// register can still take one more word; further words are stalled then.
// Reset (rst_n low, synchronous) empties both registers and returns the parser
// to idle with its counters and header window cleared.
module ipd_frame_extractor
  import ipd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  stage_ctl_t ctl;
  in_word_t   word;
  logic       out_free;
  logic       res_valid;
  out_word_t  res;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_data_r;

  // The result register can take a new word when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  ipd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_free (out_free),
    .ctl      (ctl),
    .word     (word)
  );

  ipd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (ctl.fire),
    .word      (word),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register valid.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.fire) begin
      out_valid_nxt = res_valid;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // The parser only steps on a held word whose outcome can be stored.
  a_fire_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fire |-> (ctl.valid && out_free))
    else $error("parser stepped into a full result register");

  // A stalled result is not overwritten.
  a_out_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled result changed");

  // Every result word carries a known kind.
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.result_kind == RK_PAYLOAD ||
                     out_data_r.result_kind == RK_EMPTY ||
                     out_data_r.result_kind == RK_TIMEOUT))
    else $error("bad result kind");
`endif

endmodule
